// ----- hw/rtl/great_circle_distance_defines.svh -----
// ----------------------------------------------------------------------------
// great circle distance: assertion macros
// clocked property helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// property checked only outside reset
`define GCD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define GCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcd_pkg
// shared constants, types and the arctangent table of the distance pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int DIST_FRAC_BITS  = 8;

  localparam int LAT_W   = 24;
  localparam int LON_W   = 25;
  localparam int ANG_W   = 26;
  localparam int DIST_W  = 26;
  localparam int RAD_W   = 16;
  localparam int STEPS   = 30;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;

  // angle lane latency and whole pipeline depth in register stages
  localparam int SC_LAT     = STEPS + 3;
  localparam int SQRT_STEPS = 31;
  localparam int PIPE_DEPTH = 1 + SC_LAT + 5 + SQRT_STEPS + 1 + STEPS + 3;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6371;

  localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;
  localparam logic [33:0] GAIN_INV_Q30    = 34'h026DD3B6A;
  localparam logic [35:0] HALF_PI_Q30     = 36'd1686629713;
  localparam logic [35:0] PI_Q30          = 36'd3373259426;

  typedef logic signed [33:0] q30_t;
  typedef logic signed [35:0] wide_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    begin
      case (idx)
        0:  v = 32'h3243F6A8;
        1:  v = 32'h1DAC6705;
        2:  v = 32'h0FADBAFC;
        3:  v = 32'h07F56EA6;
        4:  v = 32'h03FEAB76;
        5:  v = 32'h01FFD55B;
        6:  v = 32'h00FFFAAA;
        7:  v = 32'h007FFF55;
        8:  v = 32'h003FFFEA;
        9:  v = 32'h001FFFFD;
        10: v = 32'h000FFFFF;
        11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF;
        13: v = 32'h0001FFFF;
        14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF;
        16: v = 32'h00003FFF;
        17: v = 32'h00001FFF;
        18: v = 32'h00000FFF;
        19: v = 32'h000007FF;
        20: v = 32'h000003FF;
        21: v = 32'h000001FF;
        22: v = 32'h000000FF;
        23: v = 32'h0000007F;
        24: v = 32'h0000003F;
        25: v = 32'h0000001F;
        26: v = 32'h0000000F;
        27: v = 32'h00000008;
        28: v = 32'h00000004;
        29: v = 32'h00000002;
        default: v = 32'h00000000;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- hw/rtl/gcd_sincos.sv -----
// ----------------------------------------------------------------------------
// gcd_sincos
// one angle lane: reduce to a quadrant, scale to radians, pipelined cordic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_sincos (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [gcd_pkg::ANG_W-1:0]   angle,
  output gcd_pkg::q30_t                      sin_q,
  output gcd_pkg::q30_t                      cos_q
);
  import gcd_pkg::*;

  localparam int RW = ANG_W + 1;
  localparam logic signed [RW-1:0] FULL    = RW'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [RW-1:0] HALF    = RW'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [RW-1:0] QUARTER = RW'(90 << ANGLE_FRAC_BITS);
  localparam int AW = RW - 1;
  localparam int PW = AW + 27;
  localparam logic [PW-1:0] ROUND = PW'(1) << (ANGLE_FRAC_BITS + 1);

  logic signed [RW-1:0] r_wrap;
  logic [AW-1:0]        a_abs;
  logic [AW-1:0]        a_fold;
  logic                 neg_c_fold;

  logic [AW-1:0] a_r;
  logic          ns_r;
  logic          nc_r;
  logic [PW-1:0] zprod;

  q30_t x_s [0:STEPS];
  q30_t y_s [0:STEPS];
  q30_t z_s [0:STEPS];
  logic ns_s [0:STEPS];
  logic nc_s [0:STEPS];

  always_comb begin
    r_wrap = {angle[ANG_W-1], angle};
    if (r_wrap >= HALF) begin
      r_wrap = r_wrap - FULL;
    end else if (r_wrap < -HALF) begin
      r_wrap = r_wrap + FULL;
    end
    a_abs = r_wrap[RW-1] ? AW'(-r_wrap) : AW'(r_wrap);
    neg_c_fold = ($signed({1'b0, a_abs}) > QUARTER);
    a_fold = neg_c_fold ? AW'(HALF[AW-1:0] - a_abs) : a_abs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_fold;
      ns_r <= r_wrap[RW-1];
      nc_r <= neg_c_fold;
    end
  end

  assign zprod = PW'(a_r) * PW'(RAD_PER_DEG_Q32) + ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0]  <= GAIN_INV_Q30;
      y_s[0]  <= '0;
      z_s[0]  <= q30_t'(zprod[PW-1:ANGLE_FRAC_BITS+2]);
      ns_s[0] <= ns_r;
      nc_s[0] <= nc_r;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    q30_t dx;
    q30_t dy;
    q30_t at;
    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;
    assign at = q30_t'(atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_s[i][33]) begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - at;
        end else begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + at;
        end
        ns_s[i+1] <= ns_s[i];
        nc_s[i+1] <= nc_s[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= ns_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
      cos_q <= nc_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
    end
  end

endmodule

// ----- hw/rtl/great_circle_distance.sv -----
// ----------------------------------------------------------------------------
// great_circle_distance
// sphere distance of two points by the spherical law of cosines
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries one point pair per item, m_tdata the distance in
//   kilometres with 8 fraction bits. cfg_data sets the sphere radius in
//   whole kilometres (6371 after reset); cfg_ready is always high.
// pipeline: a 30-step rotation cordic, the 31-step square root and a
//   30-step vectoring cordic in series, one step a stage.
// throughput: one item per cycle while the output does not stall; all
//   stages advance together on a single enable.
// reset: all valid bits clear, the radius returns to 6371.
// stall: when m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated. Bubbles move ahead
//   whenever the output stage is empty or taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module great_circle_distance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73], zero pad
  input  logic [gcd_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // distance[25:0], zero pad
  output logic [gcd_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gcd_pkg::RAD_W-1:0]           cfg_data
);
  import gcd_pkg::*;

  localparam int DSH = 30 - DIST_FRAC_BITS;
  localparam logic [47:0] DROUND = 48'd1 << (DSH - 1);
  localparam logic [47:0] DMAX   = 48'((64'd1 << DIST_W) - 64'd1);

  logic                   en;
  logic [PIPE_DEPTH-1:0]  vld;
  logic [RAD_W-1:0]       radius;

  logic signed [ANG_W-1:0] lat_a_r;
  logic signed [ANG_W-1:0] lat_b_r;
  logic signed [ANG_W-1:0] dlon_r;

  q30_t sa, ca, sb, cb, sd_unused_cos, cd;
  q30_t cd_r;

  logic signed [67:0] p_ss;
  logic signed [67:0] p_cc;
  logic signed [37:0] t1;
  logic signed [67:0] m_cd;
  logic signed [37:0] c_sum;
  logic signed [31:0] c_r;
  logic signed [63:0] cc;
  logic signed [31:0] c_p4;

  logic [61:0]        n_s [0:SQRT_STEPS];
  logic [61:0]        r_s [0:SQRT_STEPS];
  logic signed [31:0] c_s [0:SQRT_STEPS];

  wide_t vx [0:STEPS];
  wide_t vy [0:STEPS];
  wide_t vz [0:STEPS];

  logic [31:0] ang;
  logic [47:0] prod;
  logic [47:0] dist_full;

  assign en        = !vld[PIPE_DEPTH-1] || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[PIPE_DEPTH-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  // input stage, longitude difference formed here
  always_ff @(posedge clk) begin
    if (en) begin
      lat_a_r <= ANG_W'($signed(s_tdata[23:0]));
      lat_b_r <= ANG_W'($signed(s_tdata[72:49]));
      dlon_r  <= ANG_W'($signed(s_tdata[97:73])) - ANG_W'($signed(s_tdata[48:24]));
    end
  end

  gcd_sincos u_lat_a (.clk(clk), .en(en), .angle(lat_a_r), .sin_q(sa), .cos_q(ca));
  gcd_sincos u_lat_b (.clk(clk), .en(en), .angle(lat_b_r), .sin_q(sb), .cos_q(cb));
  gcd_sincos u_dlon  (.clk(clk), .en(en), .angle(dlon_r),
                      .sin_q(sd_unused_cos), .cos_q(cd));

  // cosine of the central angle; cd waits one stage for ca * cb
  always_ff @(posedge clk) begin
    if (en) begin
      p_ss  <= sa * sb;
      p_cc  <= ca * cb;
      cd_r  <= cd;
      t1    <= p_ss[67:30];
      m_cd  <= 68'(cd_r * q30_t'(p_cc[63:30]));
      c_sum <= t1 + m_cd[67:30];
    end
  end

  always_comb begin
    if (c_sum > 38'sd1073741824) begin
      c_r = 32'sd1073741824;
    end else if (c_sum < -38'sd1073741824) begin
      c_r = -32'sd1073741824;
    end else begin
      c_r = c_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc     <= c_r * c_r;
      c_p4   <= c_r;
      n_s[0] <= 62'(62'd1 << 60) - 62'(cc);
      r_s[0] <= '0;
      c_s[0] <= c_p4;
    end
  end

  // floor square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [61:0] BITV = 62'd1 << (2 * (SQRT_STEPS - 1 - j));
    logic [61:0] trial;
    assign trial = r_s[j] + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_s[j] >= trial) begin
          n_s[j+1] <= n_s[j] - trial;
          r_s[j+1] <= (r_s[j] >> 1) + BITV;
        end else begin
          n_s[j+1] <= n_s[j];
          r_s[j+1] <= r_s[j] >> 1;
        end
        c_s[j+1] <= c_s[j];
      end
    end
  end

  // negative cosine: start a quarter turn on
  always_ff @(posedge clk) begin
    if (en) begin
      if (c_s[SQRT_STEPS][31]) begin
        vx[0] <= wide_t'({1'b0, r_s[SQRT_STEPS][30:0]});
        vy[0] <= -wide_t'(c_s[SQRT_STEPS]);
        vz[0] <= wide_t'(HALF_PI_Q30);
      end else begin
        vx[0] <= wide_t'(c_s[SQRT_STEPS]);
        vy[0] <= wide_t'({1'b0, r_s[SQRT_STEPS][30:0]});
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    wide_t dx;
    wide_t dy;
    wide_t at;
    assign dx = vy[i] >>> i;
    assign dy = vx[i] >>> i;
    assign at = wide_t'(atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + dx;
          vy[i+1] <= vy[i] - dy;
          vz[i+1] <= vz[i] + at;
        end else begin
          vx[i+1] <= vx[i] - dx;
          vy[i+1] <= vy[i] + dy;
          vz[i+1] <= vz[i] - at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vz[STEPS][35]) begin
        ang <= '0;
      end else if (vz[STEPS] > $signed(PI_Q30)) begin
        ang <= PI_Q30[31:0];
      end else begin
        ang <= vz[STEPS][31:0];
      end
      prod <= 48'(radius) * 48'(ang);
    end
  end

  assign dist_full = (prod + DROUND) >> DSH;

  always_ff @(posedge clk) begin
    if (en) begin
      if (dist_full > DMAX) begin
        m_tdata <= {{(OUT_DATA_W-DIST_W){1'b0}}, DMAX[DIST_W-1:0]};
      end else begin
        m_tdata <= {{(OUT_DATA_W-DIST_W){1'b0}}, dist_full[DIST_W-1:0]};
      end
    end
  end

endmodule

// ----- hw/rtl/gcd_checker.sv -----
// ----------------------------------------------------------------------------
// gcd_checker
// port level checks of the distance block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "great_circle_distance_defines.svh"

module gcd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [gcd_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import gcd_pkg::*;

  `GCD_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output item changed")
  `GCD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid right after reset")
  `GCD_ASSERT(a_ready_tracks_out, clk, rst, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
  `GCD_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[OUT_DATA_W-1:DIST_W] == '0, "pad bits of output item set")

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
